/* hw/rtl/swm_pkg.sv */
// Shared constants and types of the sliding-window median unit.
`default_nettype none

package swm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEFAULT_MAX_WINDOW   = 64;
  localparam int DEFAULT_SAMPLE_WIDTH = 32;

  // Configuration register file.
  localparam int              WS_W              = 7;
  localparam int              CFG_ADDR_W        = 3;
  localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 7'd3;
  localparam logic            REG_WINDOW_SIZE   = 1'b0;

  // Per-cycle control handed to each cell of the sorted row.
  typedef struct packed {
    logic take;        // a sample transfer happens this cycle
    logic flush;       // the current sample starts a new sequence
    logic empty;       // drop every held sample
    logic shift_self;  // the removed entry sits at or left of this cell
    logic shift_left;  // the removed entry sits at or left of the left neighbour
  } swm_cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/sliding_window_median_unit.sv */
// Sliding-window median unit: a sorted row of cells updated once per sample.
// The median of a full window is offered in the cycle after the sample transfer.
// Throughput: one sample per cycle while the median output is not held back by m_tready.
// Results are produced only once the window holds K samples of the current sequence.
// Reset (synchronous, active high) empties the window and sets window_size to 3.
`default_nettype none

module sliding_window_median_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
  localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire                   clk,
  input  wire                   rst,
  // Sample stream.
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire [DATA_W-1:0]      s_tdata,   // [SAMPLE_WIDTH-1:0] sample, zero padding above
  input  wire                   s_tuser,   // [0] restart
  // Median stream.
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // [SAMPLE_WIDTH-1:0] median, zero padding above
  // Configuration port.
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [CFG_ADDR_W-1:0]  paddr,
  input  wire [31:0]            pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (KW > WS_W) ? KW : WS_W;

  logic [WS_W-1:0]  window_size;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] fill_next;
  logic [SAMPLE_WIDTH-1:0] median;

  logic                    cfg_write;
  logic                    take;
  logic                    restart;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic [KW-1:0]           k_eff;
  logic [IDX_W-1:0]        k_m1;
  logic [IDX_W-1:0]        k_m2;
  logic [IDX_W-1:0]        rank;
  logic                    k_one;
  logic [IDX_W-1:0]        fill_eff;
  logic                    full;
  logic [IDX_W-1:0]        drop_idx;

  logic [SAMPLE_WIDTH-1:0] cell_value  [MAX_WINDOW];
  logic [IDX_W-1:0]        cell_age    [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] cell_merged [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   cell_valid;
  logic [MAX_WINDOW-1:0]   cell_le;
  logic [MAX_WINDOW-1:0]   cell_drop;
  logic [MAX_WINDOW-1:0]   shift;
  swm_cell_ctrl_t          ctrl [MAX_WINDOW];

  assign sample  = s_tdata[SAMPLE_WIDTH-1:0];
  assign restart = s_tuser;

  // Handshake: the output register frees up as its transfer completes.
  assign s_tready = ~m_tvalid | m_tready;
  assign take     = s_tvalid & s_tready;

  // Configuration port, always ready; window_size lives at the lowest address.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_WINDOW_SIZE);
  assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_write) begin
      window_size <= pwdata[WS_W-1:0];
    end
  end

  // Effective window length: zero acts as one, oversize is clipped.
  always_comb begin
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (CMP_W'(window_size) > CMP_W'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(window_size);
    end
  end

  assign k_m1     = IDX_W'(k_eff - 1'b1);
  assign k_m2     = IDX_W'(k_eff - 2'd2);
  assign rank     = k_m1 >> 1;
  assign k_one    = (k_eff == KW'(1));
  assign fill_eff = restart ? '0 : fill;
  assign full     = (fill_eff == k_m1);

  // Find the oldest held sample, which leaves when the window is full.
  always_comb begin
    drop_idx = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cell_drop[i] = full & cell_valid[i] & (cell_age[i] == k_m2);
      drop_idx     = drop_idx | (cell_drop[i] ? IDX_W'(i) : '0);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      shift[i] = full & ~k_one & (IDX_W'(i) >= drop_idx);
    end
  end

  // The sorted row of cells.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] l_value;
    logic [IDX_W-1:0]        l_age;
    logic                    l_valid;
    logic                    l_le;
    logic [SAMPLE_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]        r_age;
    logic                    r_valid;
    logic                    r_le;

    if (i == 0) begin : g_first
      // Nothing to the left: the new sample goes here if it is the smallest.
      assign l_value = '0;
      assign l_age   = '0;
      assign l_valid = 1'b0;
      assign l_le    = 1'b1;
    end else begin : g_inner_l
      assign l_value = cell_value[i-1];
      assign l_age   = cell_age[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_le    = cell_le[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign r_value = '0;
      assign r_age   = '0;
      assign r_valid = 1'b0;
      assign r_le    = 1'b0;
    end else begin : g_inner_r
      assign r_value = cell_value[i+1];
      assign r_age   = cell_age[i+1];
      assign r_valid = cell_valid[i+1];
      assign r_le    = cell_le[i+1];
    end

    assign ctrl[i].take       = take;
    assign ctrl[i].flush      = restart;
    assign ctrl[i].empty      = cfg_write | (take & k_one);
    assign ctrl[i].shift_self = shift[i];
    assign ctrl[i].shift_left = (i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1];

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl[i]),
      .sample      (sample),
      .left_value  (l_value),
      .left_age    (l_age),
      .left_valid  (l_valid),
      .left_le     (l_le),
      .right_value (r_value),
      .right_age   (r_age),
      .right_valid (r_valid),
      .right_le    (r_le),
      .value_out   (cell_value[i]),
      .age_out     (cell_age[i]),
      .valid_out   (cell_valid[i]),
      .le_out      (cell_le[i]),
      .merged      (cell_merged[i])
    );
  end

  // Fill count: stays at K-1 once the window is running.
  always_comb begin
    if (full) begin
      fill_next = k_one ? '0 : fill_eff;
    end else begin
      fill_next = IDX_W'(fill_eff + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_write) begin
      fill <= '0;
    end else if (take) begin
      fill <= fill_next;
    end
  end

  // Output register holding the median until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= full;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && full) begin
      median <= cell_merged[rank];
    end
  end

  assign m_tdata = DATA_W'(median);

`ifndef SYNTHESIS
  logic [MAX_WINDOW-1:0] held;
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_held
    assign held[i] = g_cell[i].u_cell.valid;
  end

  // The number of occupied cells always matches the fill count.
  a_fill_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(held) == int'(fill))
    else $error("occupied cells differ from fill count");

  // Occupied cells form an unbroken run from the low end of the row.
  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (held & MAX_WINDOW'(held + 1'b1)) == '0)
    else $error("gap in the sorted cell row");

  // The held count stays below the window length.
  a_fill_below_k: assert property (@(posedge clk) disable iff (rst)
    KW'(fill) < k_eff)
    else $error("fill count reached window length");

  // A new median only follows a sample transfer that completed a window.
  a_median_from_full: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(take && full))
    else $error("median offered without a full window");

  // Exactly one oldest entry leaves whenever a full window slides on.
  a_one_drop: assert property (@(posedge clk) disable iff (rst)
    (take && full && !k_one) |-> $onehot(cell_drop))
    else $error("oldest sample not unique");
`endif

endmodule

`default_nettype wire

/* hw/rtl/swm_cell.sv */
// One cell of the sorted row: holds a sample, its age and a valid flag.
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
  parameter int AGE_W        = 6
) (
  input  wire                    clk,
  input  wire                    rst,
  input  swm_cell_ctrl_t         ctrl,
  input  wire [SAMPLE_WIDTH-1:0] sample,
  input  wire [SAMPLE_WIDTH-1:0] left_value,
  input  wire [AGE_W-1:0]        left_age,
  input  wire                    left_valid,
  input  wire                    left_le,
  input  wire [SAMPLE_WIDTH-1:0] right_value,
  input  wire [AGE_W-1:0]        right_age,
  input  wire                    right_valid,
  input  wire                    right_le,
  output logic [SAMPLE_WIDTH-1:0] value_out,
  output logic [AGE_W-1:0]        age_out,
  output logic                    valid_out,
  output logic                    le_out,
  output logic [SAMPLE_WIDTH-1:0] merged
);

  logic [SAMPLE_WIDTH-1:0] value;
  logic [AGE_W-1:0]        age;
  logic                    valid;

  logic [SAMPLE_WIDTH-1:0] value_next;
  logic [AGE_W-1:0]        age_next;
  logic                    valid_next;

  logic [SAMPLE_WIDTH-1:0] s_value;
  logic [AGE_W-1:0]        s_age;
  logic                    s_valid;
  logic                    s_le;
  logic [SAMPLE_WIDTH-1:0] l_value;
  logic [AGE_W-1:0]        l_age;
  logic                    l_valid;
  logic                    l_le;

  // A restart hides the held contents for the sample that carries it.
  assign valid_out = valid & ~ctrl.flush;
  assign value_out = value;
  assign age_out   = age;
  assign le_out    = valid_out & ($signed(value) <= $signed(sample));

  // Content at this place once the new sample has been slotted in, before removal.
  assign merged = le_out ? value : (left_le ? sample : left_value);

  // Close the gap left by the removed entry, then insert the new sample.
  always_comb begin
    s_value = ctrl.shift_self ? right_value : value;
    s_age   = ctrl.shift_self ? right_age   : age;
    s_valid = ctrl.shift_self ? right_valid : valid_out;
    s_le    = ctrl.shift_self ? right_le    : le_out;
    l_value = ctrl.shift_left ? value       : left_value;
    l_age   = ctrl.shift_left ? age         : left_age;
    l_valid = ctrl.shift_left ? valid_out   : left_valid;
    l_le    = ctrl.shift_left ? le_out      : left_le;
    if (s_le) begin
      value_next = s_value;
      age_next   = AGE_W'(s_age + 1'b1);
      valid_next = s_valid;
    end else if (l_le) begin
      value_next = sample;
      age_next   = '0;
      valid_next = 1'b1;
    end else begin
      value_next = l_value;
      age_next   = AGE_W'(l_age + 1'b1);
      valid_next = l_valid;
    end
  end

  // Cell storage; only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.empty) begin
      valid <= 1'b0;
    end else if (ctrl.take) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

`default_nettype wire
